@@ rtl/frustum_plane_extractor_macros.svh @@
// assertion macros for the frustum plane extractor checker
`ifndef FRUSTUM_PLANE_EXTRACTOR_MACROS_SVH
`define FRUSTUM_PLANE_EXTRACTOR_MACROS_SVH

// implication checked at every clock edge outside reset
`define FPE_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define FPE_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/fpe_pkg.sv @@
// shared constants and controller/datapath interface types
package fpe_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int PLANE_COUNT   = 6;
	localparam int COL_W         = 32;
	localparam int PLANE_W       = 3;
	localparam int SEL_W         = 2;
	localparam int SQRT_STEPS    = 32;

	typedef struct packed {
		logic               wr_row;
		logic               load;
		logic [PLANE_W-1:0] plane;
		logic               clear;
		logic               norm;
		logic               mul;
		logic               sqrt_start;
		logic               sqrt_step;
		logic               div_start;
		logic               div_step;
		logic               div_save;
		logic [SEL_W-1:0]   sel;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic norm_done;
		logic sqrt_done;
		logic div_done;
	} sts_t;

endpackage

@@ rtl/fpe_ctrl.sv @@
// controller state machine sequencing load, normalize, multiply, square root, divide and output
module fpe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tlast,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  fpe_pkg::sts_t sts,
	output fpe_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LOAD   = 4'd1;
	localparam logic [3:0] ST_CHECK  = 4'd2;
	localparam logic [3:0] ST_NORM   = 4'd3;
	localparam logic [3:0] ST_MUL    = 4'd4;
	localparam logic [3:0] ST_SQRT_S = 4'd5;
	localparam logic [3:0] ST_SQRT   = 4'd6;
	localparam logic [3:0] ST_DIV_S  = 4'd7;
	localparam logic [3:0] ST_DIV    = 4'd8;
	localparam logic [3:0] ST_OUT    = 4'd9;

	localparam logic [fpe_pkg::SEL_W-1:0] SEL_LAST = '1;
	localparam logic [fpe_pkg::PLANE_W-1:0] PLANE_LAST =
		fpe_pkg::PLANE_W'(fpe_pkg::PLANE_COUNT - 1);

	logic [3:0]                   state_q, state_d;
	logic [fpe_pkg::SEL_W-1:0]    sel_q, sel_d;
	logic [fpe_pkg::PLANE_W-1:0]  plane_q, plane_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= '0;
			plane_q <= '0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			plane_q <= plane_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sel_d    = sel_q;
		plane_d  = plane_q;
		cmd      = '0;
		cmd.plane = plane_q;
		cmd.sel  = sel_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.wr_row = 1'b1;
					if (s_tlast) begin
						plane_d = '0;
						state_d = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.zero) begin
					cmd.clear = 1'b1;
					state_d   = ST_OUT;
				end else begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (sts.norm_done) begin
					sel_d   = '0;
					state_d = ST_MUL;
				end else begin
					cmd.norm = 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				sel_d   = sel_q + 1'b1;
				if (sel_q == SEL_LAST) begin
					state_d = ST_SQRT_S;
				end
			end
			ST_SQRT_S: begin
				cmd.sqrt_start = 1'b1;
				state_d        = ST_SQRT;
			end
			ST_SQRT: begin
				if (sts.sqrt_done) begin
					sel_d   = '0;
					state_d = ST_DIV_S;
				end else begin
					cmd.sqrt_step = 1'b1;
				end
			end
			ST_DIV_S: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.div_save = 1'b1;
					sel_d        = sel_q + 1'b1;
					state_d      = (sel_q == SEL_LAST) ? ST_OUT : ST_DIV_S;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (plane_q == PLANE_LAST) begin
						state_d = ST_IDLE;
					end else begin
						plane_d = plane_q + 1'b1;
						state_d = ST_LOAD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/fpe_datapath.sv @@
// matrix store, plane sums, normalizer, multiplier, square root and divider
module fpe_datapath #(
	parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fpe_pkg::cmd_t                 cmd,
	input  logic [1:0]                    row_index,
	input  logic [4*fpe_pkg::COL_W-1:0]   row_data,
	output fpe_pkg::sts_t                 sts,
	output logic [4*fpe_pkg::COL_W-1:0]   res_data,
	output logic [fpe_pkg::PLANE_W-1:0]   plane_index,
	output logic                          degenerate
);

	localparam int DIV_BASE = 33 + FRAC_BITS;
	localparam int DIV_MAX  = DIV_BASE + 30;
	localparam int CW       = $clog2(DIV_MAX + 1);
	localparam int SCW      = $clog2(fpe_pkg::SQRT_STEPS + 1);

	logic [31:0] mat_q [4][4];
	logic [32:0] mag_q [4];
	logic        neg_q [4];
	logic signed [5:0] sh_q;
	logic [fpe_pkg::PLANE_W-1:0] plane_q;
	logic [61:0] prod_q;
	logic [63:0] acc_q;
	logic [63:0] rad_q;
	logic [32:0] rem_q;
	logic [31:0] root_q;
	logic [SCW-1:0] scnt_q;
	logic [32:0] numsh_q;
	logic [31:0] drem_q;
	logic [31:0] quo_q;
	logic        ovf_q;
	logic [CW-1:0] dcnt_q;
	logic [31:0] res_q [4];

	logic [32:0] mag_d [4];
	logic        neg_d [4];
	logic [32:0] mmax;
	logic [32:0] m01;
	logic [34:0] srem2;
	logic [34:0] strial;
	logic [32:0] drem2;
	logic        dge;
	logic        big;
	logic [31:0] sat_val;
	logic        sub;
	logic [1:0]  krow;

	always_comb begin
		logic [32:0] a;
		logic [32:0] b;
		logic [32:0] v;
		sub  = (cmd.plane == 3'd0) || (cmd.plane == 3'd3) || (cmd.plane == 3'd4);
		krow = cmd.plane[2:1];
		for (int c = 0; c < 4; c++) begin
			a = {mat_q[3][c][31], mat_q[3][c]};
			b = {mat_q[krow][c][31], mat_q[krow][c]};
			v = sub ? (a - b) : (a + b);
			neg_d[c] = v[32];
			mag_d[c] = v[32] ? (~v + 33'd1) : v;
		end
	end

	assign m01  = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
	assign mmax = (m01 > mag_q[2]) ? m01 : mag_q[2];

	assign srem2  = {rem_q[32:0], rad_q[63:62]};
	assign strial = {1'b0, root_q, 2'b01};

	assign drem2 = {drem_q, numsh_q[32]};
	assign dge   = drem2 >= {1'b0, root_q};

	assign big     = ovf_q | quo_q[31];
	assign sat_val = neg_q[cmd.sel] ? (big ? 32'h8000_0000 : (~quo_q + 32'd1))
	                                : (big ? 32'h7FFF_FFFF : quo_q);

	assign sts.zero      = (mmax == 33'd0);
	assign sts.norm_done = (mmax[32:31] == 2'b00) && mmax[30];
	assign sts.sqrt_done = (scnt_q == SCW'(fpe_pkg::SQRT_STEPS));
	assign sts.div_done  = (dcnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					mat_q[r][c] <= '0;
				end
			end
			scnt_q <= '0;
			dcnt_q <= '0;
		end else begin
			if (cmd.wr_row) begin
				for (int c = 0; c < 4; c++) begin
					mat_q[row_index][c] <= row_data[c*32 +: 32];
				end
			end
			if (cmd.sqrt_start) begin
				scnt_q <= '0;
			end else if (cmd.sqrt_step) begin
				scnt_q <= scnt_q + 1'b1;
			end
			if (cmd.div_start) begin
				dcnt_q <= (cmd.sel == 2'd3) ? (CW'(DIV_BASE) + CW'(sh_q)) : CW'(DIV_BASE);
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int c = 0; c < 4; c++) begin
				mag_q[c] <= mag_d[c];
				neg_q[c] <= neg_d[c];
			end
			sh_q    <= '0;
			plane_q <= cmd.plane;
			prod_q  <= '0;
			acc_q   <= '0;
		end
		if (cmd.norm) begin
			if (mmax[32:31] != 2'b00) begin
				for (int c = 0; c < 3; c++) begin
					mag_q[c] <= mag_q[c] >> 1;
				end
				sh_q <= sh_q - 6'sd1;
			end else begin
				for (int c = 0; c < 3; c++) begin
					mag_q[c] <= mag_q[c] << 1;
				end
				sh_q <= sh_q + 6'sd1;
			end
		end
		if (cmd.mul) begin
			prod_q <= (cmd.sel == 2'd3) ? 62'd0 : (mag_q[cmd.sel][30:0] * mag_q[cmd.sel][30:0]);
			acc_q  <= acc_q + {2'b00, prod_q};
		end
		if (cmd.sqrt_start) begin
			rad_q  <= acc_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= rad_q << 2;
			if (srem2 >= strial) begin
				rem_q  <= 33'(srem2 - strial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= srem2[32:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.div_start) begin
			numsh_q <= mag_q[cmd.sel];
			drem_q  <= '0;
			quo_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.div_step) begin
			numsh_q <= numsh_q << 1;
			drem_q  <= dge ? 32'(drem2 - {1'b0, root_q}) : drem2[31:0];
			quo_q   <= {quo_q[30:0], dge};
			ovf_q   <= ovf_q | quo_q[31];
		end
		if (cmd.clear) begin
			for (int c = 0; c < 4; c++) begin
				res_q[c] <= '0;
			end
		end
		if (cmd.div_save) begin
			res_q[cmd.sel] <= sat_val;
		end
	end

	assign res_data    = {res_q[3], res_q[2], res_q[1], res_q[0]};
	assign plane_index = plane_q;
	assign degenerate  = sts.zero;

endmodule

@@ rtl/frustum_plane_extractor.sv @@
// top level of the frustum plane extractor: controller plus datapath
//
// Input stream: one word per matrix row. s_tuser selects the row (0 to 3),
// s_tdata carries its four signed Q16.16 entries, s_tlast marks the final
// row of a matrix. Rows not written since reset read as zero.
// After a word with s_tlast the block emits six plane words on the output
// stream in the order right, left, bottom, top, far, near; m_tlast marks the
// sixth. Each plane is normalized by the length of its xyz normal.
// Sequence: a row without s_tlast is written and the block stays ready for
// the next row. Each plane is then loaded and tested, normalized, its squared
// xyz terms multiplied and summed, and its length found by the square root;
// the four coefficients are divided by that length one after another, and
// the plane word is output. The square root and the divider make one bit per
// cycle. A degenerate plane goes from the test straight to the output.
// s_tready is low from the final row until the sixth plane is taken.
// A stalled receiver holds the current plane word; work resumes once taken.
// Reset clears the matrix to zero and returns the block to accepting rows.
module frustum_plane_extractor #(
	parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // col0_value, col1_value, col2_value, col3_value
	input  logic [1:0]   s_tuser,  // row_index
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // normal_x, normal_y, normal_z, offset_w
	output logic [3:0]   m_tuser,  // plane_index, degenerate
	output logic         m_tlast
);

	fpe_pkg::cmd_t                cmd;
	fpe_pkg::sts_t                sts;
	logic [fpe_pkg::PLANE_W-1:0]  plane_index;
	logic                         degenerate;

	fpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fpe_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.row_index   (s_tuser),
		.row_data    (s_tdata),
		.sts         (sts),
		.res_data    (m_tdata),
		.plane_index (plane_index),
		.degenerate  (degenerate)
	);

	assign m_tuser = {degenerate, plane_index};
	assign m_tlast = (plane_index == fpe_pkg::PLANE_W'(fpe_pkg::PLANE_COUNT - 1));

endmodule

@@ rtl/fpe_checker.sv @@
// port-level checker for the frustum plane extractor, bound to the top level
`include "frustum_plane_extractor_macros.svh"

module fpe_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [3:0]   m_tuser,
	input logic         m_tlast
);

	// input is closed while planes are being delivered
	`FPE_ASSERT_IMPL(a_no_overlap, m_tvalid, !s_tready, "input open while a plane word is out")

	// stalled plane word holds
	`FPE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled plane word changed")

	// last flag only on the sixth plane
	`FPE_ASSERT_IMPL(a_last, m_tvalid, m_tlast == (m_tuser[2:0] == 3'd5), "last flag does not match plane index")

	// degenerate plane carries zero coefficients
	`FPE_ASSERT_IMPL(a_degen, m_tvalid && m_tuser[3], m_tdata == 128'd0, "degenerate plane with nonzero data")

endmodule

bind frustum_plane_extractor fpe_checker u_fpe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
